### rtl/core/mbm_pkg.sv
// ----------------------------------------------------------------------------
// mbm_pkg
// Shared types, codes and the sequencer control store for the microcoded
// bus machine.
// ----------------------------------------------------------------------------
package mbm_pkg;

    localparam int CFG_ROWS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DATA_W     = 4;
    localparam int ROW_W      = 3;
    localparam int SLOT_W     = 2;
    localparam int CMD_W      = 6;
    localparam int UWORD_W    = 8;
    localparam int OP_W       = 5;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CNT_W  = 3;

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [UWORD_W-1:0] uword_t;

    // bus sources; codes 6 and 7 read as zero
    typedef enum logic [2:0] {
        SRC_RI  = 3'd0,
        SRC_A   = 3'd1,
        SRC_B   = 3'd2,
        SRC_C   = 3'd3,
        SRC_ALU = 3'd4,
        SRC_EXT = 3'd5
    } src_t;

    // bus destinations; code 7 writes nothing
    typedef enum logic [2:0] {
        DST_RI  = 3'd0,
        DST_A   = 3'd1,
        DST_B   = 3'd2,
        DST_C   = 3'd3,
        DST_R1  = 3'd4,
        DST_R2  = 3'd5,
        DST_OUT = 3'd6
    } dst_t;

    typedef enum logic [OP_W-1:0] {
        ALU_ZERO       = 5'd0,
        ALU_DIV        = 5'd1,
        ALU_MUL_DEC    = 5'd2,
        ALU_ADD        = 5'd3,
        ALU_SQ_SUB_SQ  = 5'd4,
        ALU_DOUBLE     = 5'd5,
        ALU_AVG        = 5'd6,
        ALU_MUL        = 5'd7,
        ALU_MOD        = 5'd8,
        ALU_HALF       = 5'd9,
        ALU_MUL_SUB    = 5'd10,
        ALU_SUB        = 5'd11,
        ALU_DIFF_SQ    = 5'd12,
        ALU_PASS_A     = 5'd13,
        ALU_SQUARE     = 5'd14,
        ALU_DEC        = 5'd15,
        ALU_NOT_A      = 5'd16,
        ALU_NAND       = 5'd17,
        ALU_NA_OR_B    = 5'd18,
        ALU_ONES       = 5'd19,
        ALU_XOR        = 5'd20,
        ALU_XOR_ALT    = 5'd21,
        ALU_NA_OR_B2   = 5'd22,
        ALU_OR         = 5'd23,
        ALU_A_ANDN_B   = 5'd24,
        ALU_A_ORN_B    = 5'd25,
        ALU_AND        = 5'd26,
        ALU_XNOR       = 5'd27,
        ALU_NOT_B      = 5'd28,
        ALU_NOR        = 5'd29,
        ALU_XNOR_ALT   = 5'd30,
        ALU_XNOR_ALT2  = 5'd31
    } alu_op_t;

    // sequencer
    typedef logic [0:0] step_t;
    localparam step_t STEP_FETCH = 1'b0;
    localparam step_t STEP_EXEC  = 1'b1;

    typedef enum logic [0:0] {
        COND_IN_FIRE = 1'b0,
        COND_COMMIT  = 1'b1
    } cond_t;

    typedef struct packed {
        logic  accept;   // open the input channel
        logic  divide;   // run one divider iteration
        logic  commit;   // retire the microword into state and result
        cond_t cond;     // jump condition
        step_t target;   // next step when cond holds
        step_t alt;      // next step otherwise
    } ctl_t;

    function automatic ctl_t ucode_rom(input step_t step);
        ctl_t c;
        unique case (step)
            STEP_FETCH: c = '{accept: 1'b1, divide: 1'b0, commit: 1'b0,
                              cond: COND_IN_FIRE, target: STEP_EXEC, alt: STEP_FETCH};
            STEP_EXEC:  c = '{accept: 1'b0, divide: 1'b1, commit: 1'b1,
                              cond: COND_COMMIT, target: STEP_FETCH, alt: STEP_EXEC};
        endcase
        return c;
    endfunction

    function automatic alu_op_t alu_op_of(input logic [CMD_W-1:0] cmd);
        return alu_op_t'({cmd[5:2], cmd[0]});
    endfunction

endpackage

### rtl/core/mbm_if.sv
// ----------------------------------------------------------------------------
// mbm_if
// Valid/ready channels of the microcoded bus machine: request and response.
// ----------------------------------------------------------------------------
interface mbm_req_if;
    logic                valid;
    logic                ready;
    mbm_pkg::data_t      external_value;

    modport source (output valid, output external_value, input ready);
    modport sink   (input valid, input external_value, output ready);
endinterface

interface mbm_rsp_if;
    logic                valid;
    logic                ready;
    logic                out_valid;
    mbm_pkg::data_t      out_value;
    logic                input_used;
    logic                halted;
    mbm_pkg::data_t      value_a;
    mbm_pkg::data_t      value_b;
    mbm_pkg::data_t      value_c;

    modport source (output valid, output out_valid, output out_value, output input_used,
                    output halted, output value_a, output value_b, output value_c,
                    input ready);
    modport sink   (input valid, input out_valid, input out_value, input input_used,
                    input halted, input value_a, input value_b, input value_c,
                    output ready);
endinterface

### rtl/core/mbm_alu.sv
// ----------------------------------------------------------------------------
// mbm_alu
// 4-bit ALU, 32 operations, results mod 16. Quotient and remainder come
// from the iterative divider in the top level.
// ----------------------------------------------------------------------------
module mbm_alu (
    input  mbm_pkg::alu_op_t op,
    input  mbm_pkg::data_t   a,
    input  mbm_pkg::data_t   b,
    input  mbm_pkg::data_t   quotient,
    input  mbm_pkg::data_t   remainder,
    output mbm_pkg::data_t   result
);

    logic [7:0]     ab_full;
    logic [7:0]     aa_full;
    logic [7:0]     bb_full;
    logic [7:0]     dd_full;
    logic [4:0]     sum;
    mbm_pkg::data_t diff;
    logic           b_zero;

    assign ab_full = {4'b0, a} * {4'b0, b};
    assign aa_full = {4'b0, a} * {4'b0, a};
    assign bb_full = {4'b0, b} * {4'b0, b};
    assign sum     = {1'b0, a} + {1'b0, b};
    assign diff    = a - b;
    assign dd_full = {4'b0, diff} * {4'b0, diff};
    assign b_zero  = (b == '0);

    always_comb
    begin
        unique case (op)
            mbm_pkg::ALU_ZERO:      result = '0;
            mbm_pkg::ALU_DIV:       result = b_zero ? '0 : quotient;
            mbm_pkg::ALU_MUL_DEC:   result = ab_full[3:0] - 4'd1;
            mbm_pkg::ALU_ADD:       result = sum[3:0];
            mbm_pkg::ALU_SQ_SUB_SQ: result = aa_full[3:0] - bb_full[3:0];
            mbm_pkg::ALU_DOUBLE:    result = {a[2:0], 1'b0};
            mbm_pkg::ALU_AVG:       result = sum[4:1];
            mbm_pkg::ALU_MUL:       result = ab_full[3:0];
            mbm_pkg::ALU_MOD:       result = b_zero ? '0 : remainder;
            mbm_pkg::ALU_HALF:      result = {1'b0, a[3:1]};
            mbm_pkg::ALU_MUL_SUB:   result = ab_full[3:0] - sum[3:0];
            mbm_pkg::ALU_SUB:       result = diff;
            mbm_pkg::ALU_DIFF_SQ:   result = dd_full[3:0];
            mbm_pkg::ALU_PASS_A:    result = a;
            mbm_pkg::ALU_SQUARE:    result = aa_full[3:0];
            mbm_pkg::ALU_DEC:       result = a - 4'd1;
            mbm_pkg::ALU_NOT_A:     result = ~a;
            mbm_pkg::ALU_NAND:      result = ~(a & b);
            mbm_pkg::ALU_NA_OR_B,
            mbm_pkg::ALU_NA_OR_B2:  result = ~a | b;
            mbm_pkg::ALU_ONES:      result = '1;
            mbm_pkg::ALU_XOR,
            mbm_pkg::ALU_XOR_ALT:   result = a ^ b;
            mbm_pkg::ALU_OR:        result = a | b;
            mbm_pkg::ALU_A_ANDN_B:  result = a & ~b;
            mbm_pkg::ALU_A_ORN_B:   result = a | ~b;
            mbm_pkg::ALU_AND:       result = a & b;
            mbm_pkg::ALU_XNOR,
            mbm_pkg::ALU_XNOR_ALT,
            mbm_pkg::ALU_XNOR_ALT2: result = ~(a ^ b);
            mbm_pkg::ALU_NOT_B:     result = ~b;
            mbm_pkg::ALU_NOR:       result = ~(a | b);
        endcase
    end

endmodule

### rtl/core/microcoded_bus_machine.sv
// ----------------------------------------------------------------------------
// microcoded_bus_machine
// Bus machine driven by a 32-word microcode store; one input word runs one
// microword and returns one response word.
// ----------------------------------------------------------------------------
//  channel    dir   handshake       payload
//  request    in    valid/ready     external_value[3:0]
//  response   out   valid/ready     out_valid, out_value, input_used, halted,
//                                   value_a, value_b, value_c
//  cfg        in    cfg_write       cfg_index[2:0], cfg_data[31:0]
//
//  A word runs a fetch step, then an execute step. ALU divide and modulo
//  hold the execute step while the radix-2 divider iterates.
//  Response sits in an output register; the next request is taken while it
//  waits. The execute step holds while that register is full and not taken.
//  Reset clears microcode, machine registers and counters; no clearing pass.
// ----------------------------------------------------------------------------
module microcoded_bus_machine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    mbm_req_if.sink                            request,
    mbm_rsp_if.source                          response
);

    // microcode store and machine state
    logic [mbm_pkg::CFG_DATA_W-1:0] microcode_reg [mbm_pkg::CFG_ROWS];
    mbm_pkg::data_t                 a_reg, a_next;
    mbm_pkg::data_t                 b_reg, b_next;
    mbm_pkg::data_t                 c_reg, c_next;
    mbm_pkg::data_t                 op1_reg, op1_next;
    mbm_pkg::data_t                 op2_reg, op2_next;
    logic [mbm_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [mbm_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [mbm_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic                           stopped_reg, stopped_next;

    // sequencer
    mbm_pkg::step_t                 step_reg, step_next;
    mbm_pkg::ctl_t                  ctl;
    logic                           cond_true;

    // fetched word
    mbm_pkg::uword_t                word_reg;
    mbm_pkg::data_t                 ext_reg;

    // divider
    mbm_pkg::data_t                 quo_reg;
    mbm_pkg::data_t                 rem_reg;
    logic [mbm_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [5:0]                     div_trial;
    logic                           div_needed;
    logic                           div_done;
    mbm_pkg::alu_op_t               alu_op;
    mbm_pkg::data_t                 alu_result;

    // response register
    logic                           rsp_valid_reg;
    logic                           rsp_out_valid_reg;
    mbm_pkg::data_t                 rsp_out_value_reg;
    logic                           rsp_input_used_reg;
    logic                           rsp_halted_reg;
    mbm_pkg::data_t                 rsp_a_reg;
    mbm_pkg::data_t                 rsp_b_reg;
    mbm_pkg::data_t                 rsp_c_reg;

    logic                           in_fire;
    logic                           out_free;
    logic                           commit_fire;
    mbm_pkg::src_t                  src;
    mbm_pkg::dst_t                  dst;
    mbm_pkg::data_t                 bus_val;
    logic                           bus_ext;
    logic                           bus_out;
    logic [mbm_pkg::ROW_W-1:0]      row_wr;

    assign ctl = mbm_pkg::ucode_rom(step_reg);

    assign request.ready = ctl.accept;
    assign in_fire       = request.valid && ctl.accept;
    assign out_free      = !rsp_valid_reg || response.ready;

    assign alu_op     = mbm_pkg::alu_op_of(cmd_reg);
    assign div_needed = (alu_op == mbm_pkg::ALU_DIV) || (alu_op == mbm_pkg::ALU_MOD);
    assign div_done   = !div_needed || (div_cnt_reg == mbm_pkg::DIV_CNT_W'(mbm_pkg::DIV_STEPS));
    assign div_trial  = {1'b0, rem_reg, quo_reg[3]} - {2'b0, op2_reg};

    assign commit_fire = ctl.commit && div_done && out_free;

    always_comb
    begin
        unique case (ctl.cond)
            mbm_pkg::COND_IN_FIRE: cond_true = in_fire;
            mbm_pkg::COND_COMMIT:  cond_true = commit_fire;
        endcase
        step_next = cond_true ? ctl.target : ctl.alt;
    end

    mbm_alu u_alu (
        .op        (alu_op),
        .a         (op1_reg),
        .b         (op2_reg),
        .quotient  (quo_reg),
        .remainder (rem_reg),
        .result    (alu_result)
    );

    // bus transfer
    assign src = mbm_pkg::src_t'(word_reg[7:5]);
    assign dst = mbm_pkg::dst_t'(word_reg[4:2]);

    always_comb
    begin
        bus_ext = 1'b0;
        unique case (src)
            mbm_pkg::SRC_RI:  bus_val = {1'b0, row_reg};
            mbm_pkg::SRC_A:   bus_val = a_reg;
            mbm_pkg::SRC_B:   bus_val = b_reg;
            mbm_pkg::SRC_C:   bus_val = c_reg;
            mbm_pkg::SRC_ALU: bus_val = alu_result;
            mbm_pkg::SRC_EXT:
            begin
                bus_val = ext_reg;
                bus_ext = 1'b1;
            end
            default:          bus_val = '0;
        endcase
    end

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        c_next   = c_reg;
        op1_next = op1_reg;
        op2_next = op2_reg;
        cmd_next = cmd_reg;
        row_wr   = row_reg;
        bus_out  = 1'b0;
        unique case (dst)
            mbm_pkg::DST_RI:  row_wr   = bus_val[mbm_pkg::ROW_W-1:0];
            mbm_pkg::DST_A:   a_next   = bus_val;
            mbm_pkg::DST_B:   b_next   = bus_val;
            mbm_pkg::DST_C:   c_next   = bus_val;
            mbm_pkg::DST_R1:  op1_next = bus_val;
            mbm_pkg::DST_R2:  op2_next = bus_val;
            mbm_pkg::DST_OUT: bus_out  = 1'b1;
            default:          bus_out  = 1'b0;
        endcase
        if (dst == mbm_pkg::DST_RI || dst == mbm_pkg::DST_R1 || dst == mbm_pkg::DST_R2)
        begin
            cmd_next = {cmd_reg[mbm_pkg::CMD_W-3:0], word_reg[1:0]};
        end
        slot_next    = slot_reg + 1'b1;
        row_next     = (slot_next == '0) ? row_wr + 1'b1 : row_wr;
        stopped_next = (slot_next == '0) && (row_next == '0);
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mbm_pkg::CFG_ROWS; i++)
            begin
                microcode_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            microcode_reg[cfg_index] <= cfg_data;
        end
    end

    // machine state, sequencer and divider control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            op1_reg       <= '0;
            op2_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            cmd_reg       <= '0;
            stopped_reg   <= 1'b0;
            step_reg      <= mbm_pkg::STEP_FETCH;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (in_fire)
            begin
                div_cnt_reg <= '0;
            end
            else if (ctl.divide && !div_done)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (commit_fire && !stopped_reg)
            begin
                a_reg       <= a_next;
                b_reg       <= b_next;
                c_reg       <= c_next;
                op1_reg     <= op1_next;
                op2_reg     <= op2_next;
                row_reg     <= row_next;
                slot_reg    <= slot_next;
                cmd_reg     <= cmd_next;
                stopped_reg <= stopped_next;
            end
            if (commit_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            word_reg <= microcode_reg[row_reg][{slot_reg, 3'b000} +: mbm_pkg::UWORD_W];
            ext_reg  <= request.external_value;
            quo_reg  <= op1_reg;
            rem_reg  <= '0;
        end
        else if (ctl.divide && !div_done)
        begin
            // restoring step: shift in the next dividend bit, subtract if it fits
            if (!div_trial[5])
            begin
                rem_reg <= div_trial[3:0];
                quo_reg <= {quo_reg[2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[2:0], quo_reg[3]};
                quo_reg <= {quo_reg[2:0], 1'b0};
            end
        end
        if (commit_fire)
        begin
            if (stopped_reg)
            begin
                rsp_out_valid_reg  <= 1'b0;
                rsp_out_value_reg  <= '0;
                rsp_input_used_reg <= 1'b0;
                rsp_halted_reg     <= 1'b1;
                rsp_a_reg          <= a_reg;
                rsp_b_reg          <= b_reg;
                rsp_c_reg          <= c_reg;
            end
            else
            begin
                rsp_out_valid_reg  <= bus_out;
                rsp_out_value_reg  <= bus_out ? bus_val : '0;
                rsp_input_used_reg <= bus_ext;
                rsp_halted_reg     <= stopped_next;
                rsp_a_reg          <= a_next;
                rsp_b_reg          <= b_next;
                rsp_c_reg          <= c_next;
            end
        end
    end

    assign response.valid      = rsp_valid_reg;
    assign response.out_valid  = rsp_out_valid_reg;
    assign response.out_value  = rsp_out_value_reg;
    assign response.input_used = rsp_input_used_reg;
    assign response.halted     = rsp_halted_reg;
    assign response.value_a    = rsp_a_reg;
    assign response.value_b    = rsp_b_reg;
    assign response.value_c    = rsp_c_reg;

endmodule

### rtl/core/mbm_checker.sv
// ----------------------------------------------------------------------------
// mbm_checker
// Port-level checks for the microcoded bus machine, bound to the top level.
// ----------------------------------------------------------------------------
module mbm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input logic           rsp_out_valid,
    input mbm_pkg::data_t rsp_out_value,
    input logic           rsp_input_used,
    input logic           rsp_halted,
    input mbm_pkg::data_t rsp_a,
    input mbm_pkg::data_t rsp_b,
    input mbm_pkg::data_t rsp_c
);

    logic       req_fire;
    logic       rsp_fire;
    logic [1:0] pend_reg, pend_next;
    logic       seen_halt_reg;

    assign req_fire  = req_valid && req_ready;
    assign rsp_fire  = rsp_valid && rsp_ready;
    assign pend_next = pend_reg + {1'b0, req_fire} - {1'b0, rsp_fire};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            seen_halt_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (rsp_fire && rsp_halted)
            begin
                seen_halt_reg <= 1'b1;
            end
        end
    end

    // a response word needs a request word still in flight
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without outstanding request");

    // one word in execution plus one in the output register at most
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many words in flight");

    // after the halt, responses report halted with no output and no input used
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && seen_halt_reg |-> rsp_halted && !rsp_out_valid && !rsp_input_used)
        else $error("activity after halt");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_valid)
            && $stable(rsp_out_value) && $stable(rsp_input_used) && $stable(rsp_halted)
            && $stable(rsp_a) && $stable(rsp_b) && $stable(rsp_c))
        else $error("stalled response changed");

endmodule

bind microcoded_bus_machine mbm_checker u_mbm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (request.valid),
    .req_ready      (request.ready),
    .rsp_valid      (response.valid),
    .rsp_ready      (response.ready),
    .rsp_out_valid  (response.out_valid),
    .rsp_out_value  (response.out_value),
    .rsp_input_used (response.input_used),
    .rsp_halted     (response.halted),
    .rsp_a          (response.value_a),
    .rsp_b          (response.value_b),
    .rsp_c          (response.value_c)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the microcoded bus machine word by word against an in-bench model
// of its registers, counters and ALU. A short table of steps comes first,
// then cleared, all-ones and random microcode programs under three idling
// mixes, and finally a program that runs into the halt and keeps stepping.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WORDS_PER_LOAD = 100;

    // codes the package enums leave out
    localparam logic [2:0] SRC_ZERO_LO = 3'd6;
    localparam logic [2:0] SRC_ZERO_HI = 3'd7;
    localparam logic [2:0] DST_NONE    = 3'd7;

    localparam int PROG_CLEAR  = 0;
    localparam int PROG_FULL   = 1;
    localparam int PROG_RANDOM = 2;
    localparam int PROG_HALT   = 3;

    typedef struct packed {
        logic           out_valid;
        mbm_pkg::data_t out_value;
        logic           input_used;
        logic           halted;
        mbm_pkg::data_t value_a;
        mbm_pkg::data_t value_b;
        mbm_pkg::data_t value_c;
    } machine_result_t;

    typedef struct packed {
        logic [2:0]      src;
        logic [2:0]      dst;
        logic [1:0]      cmd;
        mbm_pkg::data_t  ext;
        logic            known;
        machine_result_t res;
    } step_row_t;

    localparam machine_result_t NO_RES = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [mbm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mbm_pkg::CFG_DATA_W-1:0] cfg_data;

    mbm_req_if req_ch ();
    mbm_rsp_if rsp_ch ();

    microcoded_bus_machine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_ch),
        .response  (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // machine copy
    logic [31:0]    ctl_store [mbm_pkg::CFG_ROWS];
    logic [31:0]    next_rows [mbm_pkg::CFG_ROWS];
    mbm_pkg::data_t a_q, b_q, c_q, r1_q, r2_q;
    logic [2:0]     ri_q;
    logic [1:0]     rc_q;
    logic [5:0]     cmd_q;
    logic           halt_q;
    bit             alu_seen [32];

    machine_result_t responses_due [$];
    int send_idle, recv_idle;
    int words_sent, responses_seen, mismatches, loads, quiet_cycles;

    function automatic mbm_pkg::data_t alu_eval();
        int unsigned      x, y, r;
        mbm_pkg::alu_op_t op;
        x  = r1_q;
        y  = r2_q;
        op = mbm_pkg::alu_op_t'({cmd_q[5:2], cmd_q[0]});
        alu_seen[op] = 1'b1;
        case (op)
            mbm_pkg::ALU_ZERO:      r = 0;
            mbm_pkg::ALU_DIV:       r = (y != 0) ? x / y : 0;
            mbm_pkg::ALU_MUL_DEC:   r = x * y - 1;
            mbm_pkg::ALU_ADD:       r = x + y;
            mbm_pkg::ALU_SQ_SUB_SQ: r = x * x - y * y;
            mbm_pkg::ALU_DOUBLE:    r = x * 2;
            mbm_pkg::ALU_AVG:       r = (x + y) / 2;
            mbm_pkg::ALU_MUL:       r = x * y;
            mbm_pkg::ALU_MOD:       r = (y != 0) ? x % y : 0;
            mbm_pkg::ALU_HALF:      r = x / 2;
            mbm_pkg::ALU_MUL_SUB:   r = (x * y) - (x + y);
            mbm_pkg::ALU_SUB:       r = x - y;
            mbm_pkg::ALU_DIFF_SQ:   r = (x - y) * (x - y);
            mbm_pkg::ALU_PASS_A:    r = x;
            mbm_pkg::ALU_SQUARE:    r = x * x;
            mbm_pkg::ALU_DEC:       r = x - 1;
            mbm_pkg::ALU_NOT_A:     r = ~x;
            mbm_pkg::ALU_NAND:      r = ~(x & y);
            mbm_pkg::ALU_NA_OR_B,
            mbm_pkg::ALU_NA_OR_B2:  r = ~x | y;
            mbm_pkg::ALU_ONES:      r = 15;
            mbm_pkg::ALU_XOR,
            mbm_pkg::ALU_XOR_ALT:   r = x ^ y;
            mbm_pkg::ALU_OR:        r = x | y;
            mbm_pkg::ALU_A_ANDN_B:  r = x & ~y;
            mbm_pkg::ALU_A_ORN_B:   r = x | ~y;
            mbm_pkg::ALU_AND:       r = x & y;
            mbm_pkg::ALU_NOT_B:     r = ~y;
            mbm_pkg::ALU_NOR:       r = ~(x | y);
            default:                r = ~(x ^ y);
        endcase
        return mbm_pkg::data_t'(r);
    endfunction

    // one tick of the machine: bus move, command shift, counter advance
    function automatic machine_result_t execute_microword(input mbm_pkg::data_t ext);
        machine_result_t res;
        mbm_pkg::uword_t w;
        logic [2:0]      src, dst;
        mbm_pkg::data_t  v;
        res = '0;
        if (!halt_q) begin
            w   = ctl_store[ri_q][8*rc_q +: 8];
            src = w[7:5];
            dst = w[4:2];
            case (src)
                mbm_pkg::SRC_RI:  v = {1'b0, ri_q};
                mbm_pkg::SRC_A:   v = a_q;
                mbm_pkg::SRC_B:   v = b_q;
                mbm_pkg::SRC_C:   v = c_q;
                mbm_pkg::SRC_ALU: v = alu_eval();
                mbm_pkg::SRC_EXT:
                begin
                    v = ext;
                    res.input_used = 1'b1;
                end
                default: v = '0;
            endcase
            case (dst)
                mbm_pkg::DST_RI:  ri_q = v[2:0];
                mbm_pkg::DST_A:   a_q  = v;
                mbm_pkg::DST_B:   b_q  = v;
                mbm_pkg::DST_C:   c_q  = v;
                mbm_pkg::DST_R1:  r1_q = v;
                mbm_pkg::DST_R2:  r2_q = v;
                mbm_pkg::DST_OUT:
                begin
                    res.out_valid = 1'b1;
                    res.out_value = v;
                end
                default: ;
            endcase
            if (dst == mbm_pkg::DST_RI || dst == mbm_pkg::DST_R1 || dst == mbm_pkg::DST_R2)
                cmd_q = {cmd_q[3:0], w[1:0]};
            rc_q = rc_q + 2'd1;
            if (rc_q == 2'd0)
                ri_q = ri_q + 3'd1;
            if (ri_q == 3'd0 && rc_q == 2'd0)
                halt_q = 1'b1;
        end
        res.halted  = halt_q;
        res.value_a = a_q;
        res.value_b = b_q;
        res.value_c = c_q;
        return res;
    endfunction

    // directed steps, run in row/slot order; each jump lands on its own row
    function automatic step_row_t directed_row(input int i);
        step_row_t r;
        case (i)
            //       src, dst, cmd, ext
            //       known ov    oval   used  halt  A      B     C
            0:  r = {mbm_pkg::SRC_EXT, mbm_pkg::DST_A, 2'b00, 4'd15,
                     1'b1, 1'b0, 4'd0,  1'b1, 1'b0, 4'd15, 4'd0, 4'd0};
            1:  r = {mbm_pkg::SRC_EXT, mbm_pkg::DST_B, 2'b00, 4'd0,
                     1'b1, 1'b0, 4'd0,  1'b1, 1'b0, 4'd15, 4'd0, 4'd0};
            2:  r = {mbm_pkg::SRC_EXT, mbm_pkg::DST_OUT, 2'b00, 4'd15,
                     1'b1, 1'b1, 4'd15, 1'b1, 1'b0, 4'd15, 4'd0, 4'd0};
            3:  r = {mbm_pkg::SRC_A, mbm_pkg::DST_C, 2'b00, 4'd3,
                     1'b1, 1'b0, 4'd0,  1'b0, 1'b0, 4'd15, 4'd0, 4'd15};
            4:  r = {mbm_pkg::SRC_RI, mbm_pkg::DST_OUT, 2'b00, 4'd7,
                     1'b1, 1'b1, 4'd1,  1'b0, 1'b0, 4'd15, 4'd0, 4'd15};
            5:  r = {mbm_pkg::SRC_A, mbm_pkg::DST_R1, 2'b00, 4'd8, 1'b0, NO_RES};
            6:  r = {mbm_pkg::SRC_B, mbm_pkg::DST_R2, 2'b00, 4'd1, 1'b0, NO_RES};
            7:  r = {mbm_pkg::SRC_RI, mbm_pkg::DST_RI, 2'b01, 4'd14, 1'b0, NO_RES};
            // divide by zero
            8:  r = {mbm_pkg::SRC_ALU, mbm_pkg::DST_OUT, 2'b00, 4'd2,
                     1'b1, 1'b1, 4'd0,  1'b0, 1'b0, 4'd15, 4'd0, 4'd15};
            9:  r = {mbm_pkg::SRC_RI, mbm_pkg::DST_RI, 2'b01, 4'd4, 1'b0, NO_RES};
            10: r = {mbm_pkg::SRC_A, mbm_pkg::DST_R1, 2'b00, 4'd11, 1'b0, NO_RES};
            11: r = {mbm_pkg::SRC_B, mbm_pkg::DST_R2, 2'b00, 4'd5, 1'b0, NO_RES};
            // modulo by zero
            12: r = {mbm_pkg::SRC_ALU, mbm_pkg::DST_A, 2'b00, 4'd9,
                     1'b1, 1'b0, 4'd0,  1'b0, 1'b0, 4'd0,  4'd0, 4'd15};
            13: r = {mbm_pkg::SRC_EXT, mbm_pkg::DST_R1, 2'b10, 4'd9, 1'b0, NO_RES};
            14: r = {mbm_pkg::SRC_EXT, mbm_pkg::DST_R2, 2'b01, 4'd6, 1'b0, NO_RES};
            15: r = {mbm_pkg::SRC_RI, mbm_pkg::DST_RI, 2'b01, 4'd12, 1'b0, NO_RES};
            16: r = {mbm_pkg::SRC_ALU, mbm_pkg::DST_OUT, 2'b00, 4'd10,
                     1'b1, 1'b1, 4'd15, 1'b0, 1'b0, 4'd0,  4'd0, 4'd15};
            // undefined sources read zero
            17: r = {SRC_ZERO_LO, mbm_pkg::DST_OUT, 2'b00, 4'd13,
                     1'b1, 1'b1, 4'd0,  1'b0, 1'b0, 4'd0,  4'd0, 4'd15};
            18: r = {SRC_ZERO_HI, mbm_pkg::DST_C, 2'b00, 4'd6,
                     1'b1, 1'b0, 4'd0,  1'b0, 1'b0, 4'd0,  4'd0, 4'd0};
            // no destination: input still used, command not shifted
            19: r = {mbm_pkg::SRC_EXT, DST_NONE, 2'b11, 4'd10,
                     1'b1, 1'b0, 4'd0,  1'b1, 1'b0, 4'd0,  4'd0, 4'd0};
            20: r = {mbm_pkg::SRC_ALU, mbm_pkg::DST_OUT, 2'b00, 4'd1,
                     1'b1, 1'b1, 4'd15, 1'b0, 1'b0, 4'd0,  4'd0, 4'd0};
            21: r = {mbm_pkg::SRC_RI, mbm_pkg::DST_B, 2'b00, 4'd2, 1'b0, NO_RES};
            22: r = {mbm_pkg::SRC_EXT, mbm_pkg::DST_RI, 2'b00, 4'd13, 1'b0, NO_RES};
            default: r = {mbm_pkg::SRC_ALU, mbm_pkg::DST_OUT, 2'b00, 4'd5, 1'b0, NO_RES};
        endcase
        return r;
    endfunction

    function automatic mbm_pkg::uword_t random_microword();
        logic [2:0] s, d;
        if ($urandom_range(0, 9) == 0)
            s = 3'($urandom_range(SRC_ZERO_LO, SRC_ZERO_HI));
        else
            s = 3'($urandom_range(mbm_pkg::SRC_RI, mbm_pkg::SRC_EXT));
        if ($urandom_range(0, 7) == 0)
            d = DST_NONE;
        else
            d = 3'($urandom_range(mbm_pkg::DST_RI, mbm_pkg::DST_OUT));
        return {s, d, 2'($urandom_range(0, 3))};
    endfunction

    // a jump taken from the last slot must not land back on row 0, so the
    // external value is kept off the last row there
    function automatic mbm_pkg::data_t pick_external();
        mbm_pkg::uword_t w;
        mbm_pkg::data_t  v;
        w = ctl_store[ri_q][8*rc_q +: 8];
        v = 4'($urandom_range(0, 15));
        if (!halt_q && rc_q == 2'd3 && w[7:5] == mbm_pkg::SRC_EXT
            && w[4:2] == mbm_pkg::DST_RI && &v[2:0])
            v[2:0] = 3'($urandom_range(0, 6));
        return v;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_rows();
        for (int i = 0; i < mbm_pkg::CFG_ROWS; i++) begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= i[mbm_pkg::CFG_IDX_W-1:0];
            cfg_data  <= next_rows[i];
            ctl_store[i] = next_rows[i];
        end
        @(negedge clk);
        cfg_write <= 1'b0;
        loads++;
    endtask

    task automatic make_program(input int kind);
        mbm_pkg::uword_t w;
        for (int r = 0; r < mbm_pkg::CFG_ROWS; r++) begin
            for (int k = 0; k < 4; k++) begin
                case (kind)
                    PROG_CLEAR:            w = 8'h00;
                    PROG_FULL, PROG_HALT:  w = 8'hFF;
                    default:               w = random_microword();
                endcase
                if (kind != PROG_HALT) begin
                    // keep the machine running: last-slot jumps come only from RI or input
                    if (k == 3 && w[4:2] == mbm_pkg::DST_RI && w[7:5] != mbm_pkg::SRC_RI
                        && w[7:5] != mbm_pkg::SRC_EXT)
                        w[7:5] = mbm_pkg::SRC_EXT;
                    if (r == mbm_pkg::CFG_ROWS - 1 && k == 3)
                        w = {mbm_pkg::SRC_EXT, mbm_pkg::DST_RI, w[1:0]};
                end
                next_rows[r][8*k +: 8] = w;
            end
        end
        write_rows();
    endtask

    task automatic send_word(input mbm_pkg::data_t v, input logic known,
                             input machine_result_t fixed);
        machine_result_t due;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.external_value <= v;
        do @(posedge clk); while (!req_ch.ready);
        due = execute_microword(v);
        responses_due.push_back(known ? fixed : due);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk) begin : monitor
        machine_result_t want;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (responses_due.size() == 0) begin
                $error("response word with nothing pending");
                mismatches++;
            end
            else begin
                want = responses_due.pop_front();
                check_field("out_valid",  want.out_valid,  rsp_ch.out_valid);
                check_field("out_value",  want.out_value,  rsp_ch.out_value);
                check_field("input_used", want.input_used, rsp_ch.input_used);
                check_field("halted",     want.halted,     rsp_ch.halted);
                check_field("value_a",    want.value_a,    rsp_ch.value_a);
                check_field("value_b",    want.value_b,    rsp_ch.value_b);
                check_field("value_c",    want.value_c,    rsp_ch.value_c);
                responses_seen++;
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        step_row_t row;
        int        kind, ops_hit;
        rst_n                 = 1'b0;
        cfg_write             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        req_ch.valid          = 1'b0;
        req_ch.external_value = '0;
        a_q = '0; b_q = '0; c_q = '0; r1_q = '0; r2_q = '0;
        ri_q = '0; rc_q = '0; cmd_q = '0; halt_q = 1'b0;
        for (int i = 0; i < mbm_pkg::CFG_ROWS; i++) begin
            ctl_store[i] = '0;
            next_rows[i] = '0;
        end
        words_sent = 0; loads = 0;
        send_idle = 35;
        recv_idle = 49;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 24; i++) begin
            row = directed_row(i);
            next_rows[i / 4][8*(i % 4) +: 8] = {row.src, row.dst, row.cmd};
        end
        write_rows();
        for (int i = 0; i < 24; i++) begin
            row = directed_row(i);
            send_word(row.ext, row.known, row.res);
        end
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 35 : (phase == 1) ? 49 : 0;
            recv_idle = (phase == 0) ? 49 : (phase == 1) ? 35 : 0;
            for (int p = 0; p < 3; p++) begin
                if (p == 0 && phase == 0)
                    kind = PROG_CLEAR;
                else if (p == 0 && phase == 1)
                    kind = PROG_FULL;
                else
                    kind = PROG_RANDOM;
                make_program(kind);
                repeat (WORDS_PER_LOAD) send_word(pick_external(), 1'b0, NO_RES);
                drain();
            end
        end

        // straight-line program: runs off the end of the store and stops
        make_program(PROG_HALT);
        while (!halt_q)
            send_word(pick_external(), 1'b0, NO_RES);
        repeat (6) send_word(pick_external(), 1'b0, NO_RES);
        drain();

        ops_hit = 0;
        for (int i = 0; i < 32; i++)
            ops_hit += alu_seen[i];
        $display("%0d words over %0d microcode loads, %0d responses compared",
                 words_sent, loads, responses_seen);
        $display("%0d of 32 ALU operations used, machine halted: %0d", ops_hit, halt_q);
        if (mismatches == 0 && responses_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### files.f
rtl/core/mbm_pkg.sv
rtl/core/mbm_if.sv
rtl/core/mbm_alu.sv
rtl/core/microcoded_bus_machine.sv
rtl/core/mbm_checker.sv
dv/testbench.sv
